[rtl/bru_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bru_pkg;

  localparam logic [1:0] FMT_1BPP  = 2'd0;
  localparam logic [1:0] FMT_4BPP  = 2'd1;
  localparam logic [1:0] FMT_8BPP  = 2'd2;
  localparam logic [1:0] FMT_24BPP = 2'd3;

  localparam logic [1:0] REG_PIXEL_FORMAT = 2'd0;
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam logic OP_PALETTE = 1'b0;
  localparam logic OP_RASTER  = 1'b1;

  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_CNT_W  = 3;
  localparam int FIFO_PTR_W  = 2;
  localparam int ROW_BYTES_W = 18;

  localparam logic [20:0] ROW_ROUND = 21'd31;

  typedef struct packed {
    logic [1:0]  fmt;
    logic [15:0] width;
    logic [15:0] height;
  } cfg_t;

  typedef struct packed {
    logic        bypass;
    logic        black;
    logic [23:0] rgb;
    logic        row_end;
    logic        frame_end;
    logic        last;
  } pix_meta_t;

  typedef struct packed {
    logic [23:0] rgb;
    logic        row_end;
    logic        frame_end;
    logic        last;
  } pix_out_t;

  // bytes per row, rounded up to a 32-bit word
  function automatic logic [ROW_BYTES_W-1:0] row_size(input logic [1:0] fmt,
                                                      input logic [15:0] width);
    logic [20:0] bits;
    logic [20:0] sum;
    unique case (fmt)
      FMT_1BPP: bits = 21'(width);
      FMT_4BPP: bits = 21'({width, 2'b00});
      FMT_8BPP: bits = 21'({width, 3'b000});
      default:  bits = 21'({width, 4'b0000}) + 21'({width, 3'b000});
    endcase
    sum = bits + ROW_ROUND;
    return {sum[20:5], 2'b00};
  endfunction

endpackage

`default_nettype wire

[rtl/bru_palette_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module bru_palette_ram #(
  parameter int PALETTE_DEPTH = 256
) (
  input  wire logic                             clk,
  input  wire logic                             wr_en,
  input  wire logic [$clog2(PALETTE_DEPTH)-1:0] wr_addr,
  input  wire logic [23:0]                      wr_data,
  input  wire logic [$clog2(PALETTE_DEPTH)-1:0] rd_addr,
  output logic      [23:0]                      rd_data
);

  logic [23:0] mem [PALETTE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[rtl/bru_unpacker.sv]
`timescale 1ns / 1ps
`default_nettype none

module bru_unpacker #(
  parameter int PALETTE_DEPTH = 256
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire bru_pkg::cfg_t                             cfg,
  input  wire logic                                      in_valid,
  output logic                                           in_ready,
  input  wire logic                                      opcode,
  input  wire logic [7:0]                                palette_index,
  input  wire logic [7:0]                                palette_red,
  input  wire logic [7:0]                                palette_green,
  input  wire logic [7:0]                                palette_blue,
  input  wire logic [7:0]                                raster_byte,
  input  wire logic [bru_pkg::FIFO_CNT_W-1:0]            fifo_count,
  output logic                                           wr_en,
  output logic      [$clog2(PALETTE_DEPTH)-1:0]          wr_addr,
  output logic      [23:0]                               wr_data,
  output logic      [$clog2(PALETTE_DEPTH)-1:0]          rd_addr,
  output logic                                           push,
  output bru_pkg::pix_meta_t                             push_meta
);

  import bru_pkg::*;

  localparam int IDX_W = $clog2(PALETTE_DEPTH);

  logic                   busy;
  logic [7:0]             shreg;
  logic [2:0]             k;
  logic [ROW_BYTES_W-1:0] row_byte_count;
  logic [15:0]            row_pixel_count;
  logic [15:0]            row_count;
  logic [15:0]            held_color_bytes;
  logic [1:0]             color_byte_phase;
  logic                   s1_valid;
  pix_meta_t              s1_meta;

  logic                   accept;
  logic                   is24;
  logic                   pix_room;
  logic [16:0]            rpc_inc;
  logic [16:0]            rc_inc;
  logic                   rend;
  logic                   rc_wrap;
  logic                   fend;
  logic [2:0]             per_m1;
  logic                   k_last;
  logic [7:0]             idx8;
  logic                   idx_ok;
  logic                   emit_idx;
  logic                   emit_24;
  logic                   want_emit;
  logic                   slot_ok;
  logic                   step;
  logic                   byte_done;
  logic [ROW_BYTES_W-1:0] rbc_inc;
  logic                   row_fin;

  assign is24     = (cfg.fmt == FMT_24BPP);
  assign pix_room = (row_pixel_count < cfg.width);
  assign rpc_inc  = {1'b0, row_pixel_count} + 17'd1;
  assign rc_inc   = {1'b0, row_count} + 17'd1;
  assign rend     = (rpc_inc >= {1'b0, cfg.width});
  assign rc_wrap  = (rc_inc >= {1'b0, cfg.height});
  assign fend     = rend && rc_wrap;

  always_comb begin
    unique case (cfg.fmt)
      FMT_1BPP: begin
        per_m1 = 3'd7;
        idx8   = {7'd0, shreg[7]};
      end
      FMT_4BPP: begin
        per_m1 = 3'd1;
        idx8   = {4'd0, shreg[7:4]};
      end
      default: begin
        per_m1 = 3'd0;
        idx8   = shreg;
      end
    endcase
  end

  assign k_last  = (k == per_m1);
  assign idx_ok  = ({24'd0, idx8} < 32'(PALETTE_DEPTH));
  assign rd_addr = idx8[IDX_W-1:0];

  assign emit_idx  = !is24 && pix_room;
  assign emit_24   = is24 && pix_room && (color_byte_phase >= 2'd2);
  assign want_emit = emit_idx || emit_24;
  assign slot_ok   = (({1'b0, fifo_count} + {{FIFO_CNT_W{1'b0}}, s1_valid})
                      < (FIFO_CNT_W + 1)'(FIFO_DEPTH));
  assign step      = busy && (!want_emit || slot_ok);
  assign byte_done = step && (is24 || !pix_room || k_last || rend);

  assign in_ready = !busy || byte_done;
  assign accept   = in_valid && in_ready;

  assign wr_en   = accept && (opcode == OP_PALETTE)
                   && ({24'd0, palette_index} < 32'(PALETTE_DEPTH));
  assign wr_addr = palette_index[IDX_W-1:0];
  assign wr_data = {palette_red, palette_green, palette_blue};

  assign rbc_inc = row_byte_count + ROW_BYTES_W'(1);
  assign row_fin = (rbc_inc >= row_size(cfg.fmt, cfg.width));

  // byte sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept && (opcode == OP_RASTER)) begin
      busy <= 1'b1;
    end else if (byte_done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (opcode == OP_RASTER)) begin
      shreg <= raster_byte;
      k     <= 3'd0;
    end else if (step && emit_idx) begin
      k <= k + 3'd1;
      unique case (cfg.fmt)
        FMT_1BPP: shreg <= {shreg[6:0], 1'b0};
        FMT_4BPP: shreg <= {shreg[3:0], 4'd0};
        default:  shreg <= shreg;
      endcase
    end
  end

  // row and frame counters
  always_ff @(posedge clk) begin
    if (rst) begin
      row_byte_count   <= '0;
      row_pixel_count  <= '0;
      row_count        <= '0;
      held_color_bytes <= '0;
      color_byte_phase <= '0;
    end else if (step) begin
      if (want_emit) begin
        row_pixel_count <= rpc_inc[15:0];
      end
      if (is24 && pix_room) begin
        unique case (color_byte_phase)
          2'd0: begin
            held_color_bytes[7:0] <= shreg;
            color_byte_phase      <= 2'd1;
          end
          2'd1: begin
            held_color_bytes[15:8] <= shreg;
            color_byte_phase       <= 2'd2;
          end
          default: color_byte_phase <= 2'd0;
        endcase
      end
      if (byte_done) begin
        if (row_fin) begin
          row_byte_count   <= '0;
          row_pixel_count  <= '0;
          held_color_bytes <= '0;
          color_byte_phase <= '0;
          row_count        <= rc_wrap ? 16'd0 : rc_inc[15:0];
        end else begin
          row_byte_count <= rbc_inc;
        end
      end
    end
  end

  // palette read stage, data arrives with s1
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= step && want_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && want_emit) begin
      s1_meta.bypass    <= is24;
      s1_meta.black     <= !idx_ok;
      s1_meta.rgb       <= {shreg, held_color_bytes[15:8], held_color_bytes[7:0]};
      s1_meta.row_end   <= rend;
      s1_meta.frame_end <= fend;
      s1_meta.last      <= is24 || k_last || rend;
    end
  end

  assign push      = s1_valid;
  assign push_meta = s1_meta;

endmodule

`default_nettype wire

[rtl/bru_pixel_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

module bru_pixel_fifo (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  input  wire bru_pkg::pix_meta_t             push_meta,
  input  wire logic [23:0]                    palette_rgb,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output bru_pkg::pix_out_t                   out_pix,
  output logic      [bru_pkg::FIFO_CNT_W-1:0] count
);

  import bru_pkg::*;

  pix_out_t              entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  pix_out_t              push_pix;
  logic                  pop;

  always_comb begin
    priority if (push_meta.bypass) begin
      push_pix.rgb = push_meta.rgb;
    end else if (push_meta.black) begin
      push_pix.rgb = 24'd0;
    end else begin
      push_pix.rgb = palette_rgb;
    end
    push_pix.row_end   = push_meta.row_end;
    push_pix.frame_end = push_meta.frame_end;
    push_pix.last      = push_meta.last;
  end

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign out_pix   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      count <= count + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

[rtl/bmp_raster_unpacker_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  handshake             payload
// in       input      in_valid / in_ready   opcode, palette_*, raster_byte
// out      output     out_valid / out_ready pixel_*, row_end, frame_end, last_of_item
// cfg      input      cfg_write             cfg_index, cfg_data
//
// a palette write goes into the palette when it is accepted; a raster byte yields up to
// eight pixels, one pixel per cycle while the output queue has room
// pixels pass through the palette read stage, then through a four-entry output queue
// reset is synchronous; the palette holds no reset value and must be loaded first
// a stalled output fills the queue, then holds the byte sequencer and input ready

module bmp_raster_unpacker_unit #(
  parameter int PALETTE_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        opcode,
  input  wire logic [7:0]  palette_index,
  input  wire logic [7:0]  palette_red,
  input  wire logic [7:0]  palette_green,
  input  wire logic [7:0]  palette_blue,
  input  wire logic [7:0]  raster_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [7:0]  pixel_red,
  output logic      [7:0]  pixel_green,
  output logic      [7:0]  pixel_blue,
  output logic             row_end,
  output logic             frame_end,
  output logic             last_of_item,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  import bru_pkg::*;

  localparam int IDX_W = $clog2(PALETTE_DEPTH);

  cfg_t                  cfg;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [23:0]           wr_data;
  logic [IDX_W-1:0]      rd_addr;
  logic [23:0]           rd_data;
  logic                  push;
  pix_meta_t             push_meta;
  pix_out_t              out_pix;
  logic [FIFO_CNT_W-1:0] fifo_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fmt    <= FMT_8BPP;
      cfg.width  <= 16'd1;
      cfg.height <= 16'd1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PIXEL_FORMAT: cfg.fmt    <= cfg_data[1:0];
        REG_IMAGE_WIDTH:  cfg.width  <= cfg_data;
        REG_IMAGE_HEIGHT: cfg.height <= cfg_data;
        default:          cfg        <= cfg;
      endcase
    end
  end

  bru_unpacker #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_unpacker (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .palette_index (palette_index),
    .palette_red   (palette_red),
    .palette_green (palette_green),
    .palette_blue  (palette_blue),
    .raster_byte   (raster_byte),
    .fifo_count    (fifo_count),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .rd_addr       (rd_addr),
    .push          (push),
    .push_meta     (push_meta)
  );

  bru_palette_ram #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bru_pixel_fifo u_fifo (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_meta   (push_meta),
    .palette_rgb (rd_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_pix     (out_pix),
    .count       (fifo_count)
  );

  assign pixel_red    = out_pix.rgb[23:16];
  assign pixel_green  = out_pix.rgb[15:8];
  assign pixel_blue   = out_pix.rgb[7:0];
  assign row_end      = out_pix.row_end;
  assign frame_end    = out_pix.frame_end;
  assign last_of_item = out_pix.last;

endmodule

`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
  import bru_pkg::*;

  localparam int PAL_DEPTH = 256;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_ITEMS = 236;

  localparam logic [1:0] PH_BLUE  = 2'd0;
  localparam logic [1:0] PH_GREEN = 2'd1;
  localparam logic [1:0] PH_RED   = 2'd2;

  class pixel_scoreboard;
    logic [1:0]  fmt;
    int unsigned width;
    int unsigned height;
    logic [23:0] palette [PAL_DEPTH];
    bit          known [PAL_DEPTH];
    int unsigned byte_cnt;
    int unsigned pix_cnt;
    int unsigned row_cnt;
    logic [15:0] held;
    logic [1:0]  phase;
    pix_out_t    pixels_due [$];
    int          errors;

    function void reset();
      fmt = FMT_8BPP;
      width = 1;
      height = 1;
      foreach (known[i]) known[i] = 1'b0;
      byte_cnt = 0;
      pix_cnt = 0;
      row_cnt = 0;
      held = '0;
      phase = PH_BLUE;
      pixels_due.delete();
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        REG_PIXEL_FORMAT: fmt = data[1:0];
        REG_IMAGE_WIDTH:  width = 32'(data);
        REG_IMAGE_HEIGHT: height = 32'(data);
        default: ;
      endcase
    endfunction

    function int unsigned bpp_now();
      case (fmt)
        FMT_1BPP: return 1;
        FMT_4BPP: return 4;
        FMT_8BPP: return 8;
        default:  return 24;
      endcase
    endfunction

    function int unsigned row_bytes();
      return ((bpp_now() * width + 31) / 32) * 4;
    endfunction

    function int outstanding();
      return pixels_due.size();
    endfunction

    // true when every palette entry this byte would look up has been loaded
    function bit reads_known(logic [7:0] data);
      int unsigned bpp;
      int unsigned k;
      int unsigned entry;
      if (fmt == FMT_24BPP) return 1'b1;
      bpp = bpp_now();
      for (k = 0; k < 8 / bpp && pix_cnt + k < width; k++) begin
        entry = (data >> (8 - bpp * (k + 1))) & ((1 << bpp) - 1);
        if (entry < PAL_DEPTH && !known[entry]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function pix_out_t emit(logic [23:0] rgb);
      pix_out_t p;
      p.rgb = rgb;
      p.row_end = (pix_cnt + 1 >= width);
      p.frame_end = p.row_end && (row_cnt + 1 >= height);
      p.last = 1'b0;
      pix_cnt = (pix_cnt + 1) & 32'hFFFF;
      return p;
    endfunction

    function void note_input(logic op, logic [7:0] idx, logic [7:0] red, logic [7:0] green,
                             logic [7:0] blue, logic [7:0] data);
      pix_out_t    made [$];
      int unsigned bpp;
      int unsigned mask;
      int unsigned sh;
      int unsigned k;
      int unsigned entry;
      if (op == OP_PALETTE) begin
        if (32'(idx) < PAL_DEPTH) begin
          palette[idx] = {red, green, blue};
          known[idx] = 1'b1;
        end
        return;
      end
      if (fmt == FMT_24BPP) begin
        if (pix_cnt < width) begin
          case (phase)
            PH_BLUE: begin
              held[7:0] = data;
              phase = PH_GREEN;
            end
            PH_GREEN: begin
              held[15:8] = data;
              phase = PH_RED;
            end
            default: begin
              made = {made, emit({data, held[15:8], held[7:0]})};
              phase = PH_BLUE;
            end
          endcase
        end
      end else begin
        bpp = bpp_now();
        mask = (1 << bpp) - 1;
        for (k = 0; k < 8 / bpp && pix_cnt < width; k++) begin
          sh = 8 - bpp * (k + 1);
          entry = (data >> sh) & mask;
          made = {made, emit(entry < PAL_DEPTH ? palette[entry] : 24'h0)};
        end
      end
      if (made.size() > 0) made[made.size() - 1].last = 1'b1;
      pixels_due = {pixels_due, made};
      // row bookkeeping, padding included
      byte_cnt = (byte_cnt + 1) & 32'h3FFFF;
      if (byte_cnt >= row_bytes()) begin
        byte_cnt = 0;
        pix_cnt = 0;
        held = '0;
        phase = PH_BLUE;
        row_cnt = (row_cnt + 1 >= height) ? 0 : ((row_cnt + 1) & 32'hFFFF);
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 50) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task check_pixel(pix_out_t got);
      pix_out_t want;
      if (pixels_due.size() == 0) begin
        report($sformatf("pixel %06h with no transaction pending", got.rgb));
        return;
      end
      want = pixels_due.pop_front();
      check_field("pixel_red", got.rgb[23:16], want.rgb[23:16]);
      check_field("pixel_green", got.rgb[15:8], want.rgb[15:8]);
      check_field("pixel_blue", got.rgb[7:0], want.rgb[7:0]);
      check_field("row_end", 8'(got.row_end), 8'(want.row_end));
      check_field("frame_end", 8'(got.frame_end), 8'(want.frame_end));
      check_field("last_of_item", 8'(got.last), 8'(want.last));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        opcode;
  logic [7:0]  palette_index;
  logic [7:0]  palette_red;
  logic [7:0]  palette_green;
  logic [7:0]  palette_blue;
  logic [7:0]  raster_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  pixel_red;
  logic [7:0]  pixel_green;
  logic [7:0]  pixel_blue;
  logic        row_end;
  logic        frame_end;
  logic        last_of_item;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  bit in_pauses;
  bit out_stalls;
  pixel_scoreboard sb;

  bmp_raster_unpacker_unit #(
    .PALETTE_DEPTH(PAL_DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode(opcode),
    .palette_index(palette_index),
    .palette_red(palette_red),
    .palette_green(palette_green),
    .palette_blue(palette_blue),
    .raster_byte(raster_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .pixel_red(pixel_red),
    .pixel_green(pixel_green),
    .pixel_blue(pixel_blue),
    .row_end(row_end),
    .frame_end(frame_end),
    .last_of_item(last_of_item),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_item(input logic op, input logic [7:0] idx, input logic [7:0] red,
                           input logic [7:0] green, input logic [7:0] blue,
                           input logic [7:0] data);
    int gap;
    gap = in_pauses ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    palette_index <= idx;
    palette_red <= red;
    palette_green <= green;
    palette_blue <= blue;
    raster_byte <= data;
    do @(posedge clk); while (!in_ready);
    sb.note_input(op, idx, red, green, blue, data);
  endtask

  task automatic send_palette(input logic [7:0] idx, input logic [7:0] red,
                              input logic [7:0] green, input logic [7:0] blue);
    send_item(OP_PALETTE, idx, red, green, blue, 8'($urandom));
  endtask

  // rewrites the pixel fields of a byte that would hit an unloaded palette entry
  task automatic send_raster(input logic [7:0] want);
    logic [7:0]  data;
    int unsigned bpp;
    int unsigned k;
    int unsigned sh;
    int unsigned pick;
    data = want;
    if (!sb.reads_known(data)) begin
      bpp = sb.bpp_now();
      for (k = 0; k < 8 / bpp; k++) begin
        sh = 8 - bpp * (k + 1);
        do pick = $urandom_range(0, (1 << bpp) - 1); while (!sb.known[pick]);
        data = 8'((32'(data) & ~(((1 << bpp) - 1) << sh)) | (pick << sh));
      end
    end
    send_item(OP_RASTER, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), data);
  endtask

  task automatic load_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic configure_image(input logic [1:0] fmt, input logic [15:0] w,
                                 input logic [15:0] h);
    load_reg(REG_PIXEL_FORMAT, 16'(fmt));
    load_reg(REG_IMAGE_WIDTH, w);
    load_reg(REG_IMAGE_HEIGHT, h);
    cfg_write <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : pixel_sink
    int       stall;
    pix_out_t got;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = out_stalls ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got.rgb = {pixel_red, pixel_green, pixel_blue};
      got.row_end = row_end;
      got.frame_end = frame_end;
      got.last = last_of_item;
      sb.check_pixel(got);
    end
  end

  initial begin : stimulus
    int unsigned fmt_pick;
    int unsigned w;
    int unsigned h;
    int unsigned rows;
    int unsigned nbytes;
    int unsigned n;
    int          sent;
    int          p;
    in_valid <= 1'b0;
    opcode <= OP_RASTER;
    palette_index <= '0;
    palette_red <= '0;
    palette_green <= '0;
    palette_blue <= '0;
    raster_byte <= '0;
    cfg_write <= 1'b0;
    cfg_index <= REG_PIXEL_FORMAT;
    cfg_data <= '0;
    in_pauses = 1'b1;
    out_stalls = 1'b1;
    sb = new();
    sb.reset();
    rst <= 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // palette extremes, then reset geometry: 8 bit, one pixel per row
    send_palette(8'h00, 8'h00, 8'h00, 8'h00);
    send_palette(8'h01, 8'hFF, 8'hFF, 8'hFF);
    send_palette(8'h0F, 8'h0F, 8'hF0, 8'h3C);
    send_palette(8'hFF, 8'hA5, 8'h5A, 8'hC3);
    send_raster(8'hFF);
    send_raster(8'h00);
    send_raster(8'h0F);
    send_raster(8'h01);
    drain();

    // 1 bit, partial last byte, two rows
    configure_image(FMT_1BPP, 16'd9, 16'd2);
    send_raster(8'hA5);
    send_raster(8'h80);
    send_raster(8'h3C);
    send_raster(8'hFF);
    send_raster(8'h01);
    send_raster(8'h7F);
    drain();

    // 4 bit, leftover row closes first
    configure_image(FMT_4BPP, 16'd3, 16'd1);
    send_raster(8'h00);
    send_raster(8'hFF);
    send_raster(8'hF0);
    send_raster(8'h1F);
    drain();

    // 24 bit with zero height
    configure_image(FMT_24BPP, 16'd1, 16'd0);
    send_raster(8'h11);
    send_raster(8'h22);
    send_raster(8'h00);
    send_raster(8'h80);
    send_raster(8'hFF);
    drain();

    // zero width
    configure_image(FMT_8BPP, 16'd0, 16'd1);
    send_raster(8'h5A);

    sent = 0;
    p = 0;
    while (sent < RANDOM_ITEMS) begin
      if (p == 0) begin
        fmt_pick = FMT_1BPP;
        w = 65535;
        h = 65535;
      end else begin
        fmt_pick = $urandom_range(0, 3);
        case ($urandom_range(0, 9))
          0: w = 0;
          1: w = 65535;
          2: w = $urandom_range(13, 400);
          default: w = $urandom_range(1, 12);
        endcase
        case ($urandom_range(0, 7))
          0: h = 0;
          1: h = 65535;
          default: h = $urandom_range(1, 3);
        endcase
      end
      in_pauses = ($urandom_range(0, 3) != 0);
      out_stalls = ($urandom_range(0, 3) != 0);
      drain();
      configure_image(2'(fmt_pick), 16'(w), 16'(h));
      rows = (h >= 1 && h <= 3) ? h : 2;
      nbytes = sb.row_bytes() * rows;
      if (nbytes == 0) nbytes = 4;
      if (nbytes > 60) nbytes = 60;
      for (n = 0; n < nbytes && sent < RANDOM_ITEMS; n++) begin
        if ($urandom_range(0, 5) == 0) begin
          send_palette(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
          sent++;
        end
        send_raster(8'($urandom));
        sent++;
        if (n == nbytes / 2 && $urandom_range(0, 3) == 0) drain();
      end
      p++;
    end
    drain();

    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
